### hdl/bfra_pkg.sv
// Types and constants shared by the best-fit range allocator files.
package bfra_pkg;

    localparam logic [31:0] POOL_RESET = 32'd1073741824;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        logic        command;
        logic [31:0] block_offset;
        logic [31:0] block_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_offset;
        logic [31:0] granted_size;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_ALLOC_WR,
        S_MERGE,
        S_SCAN2,
        S_REL_WR,
        S_RESP
    } state_t;

endpackage

### hdl/best_fit_range_allocator.sv
// Best-fit free-range allocator: free table in one memory, scanned per transaction.
// Zero-size requests go straight to the result without a scan; an allocate scans the
// table once and a release twice, entry by entry through the single read port of the
// range memory.
// One transaction is in flight at a time; the next is taken after the result is taken.
// Reset (aresetn low, synchronous) marks only entry 0 valid; the cycle after reset
// loads entry 0 with the default pool, during which no transaction is accepted.
module best_fit_range_allocator import bfra_pkg::*; #(
    parameter int MAX_FREE_RANGES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  req_t        s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rsp_t        m_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int IW = (MAX_FREE_RANGES > 1) ? $clog2(MAX_FREE_RANGES) : 1;
    localparam logic [IW:0] LAST_CNT = (IW+1)'(MAX_FREE_RANGES);

    // start in [63:32], length in [31:0]
    logic [63:0] mem [MAX_FREE_RANGES];
    logic [63:0] rd_data;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic [63:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    logic [MAX_FREE_RANGES-1:0] valid_reg, valid_next;
    state_t state_reg, state_next;
    logic   init_reg;

    logic [IW:0]   cnt_reg, cnt_next;
    logic          pend_reg;
    logic          pval_reg;
    logic [IW-1:0] pidx_reg;

    req_t req_reg;
    rsp_t rsp_reg, rsp_next;

    // scan results
    logic          fa_reg, fa_next;      // best / prev found
    logic [IW-1:0] ia_reg, ia_next;
    logic [31:0]   sa_reg, sa_next, la_reg, la_next;
    logic          fb_reg, fb_next;      // next found
    logic [IW-1:0] ib_reg, ib_next;
    logic [31:0]   sb_reg, sb_next, lb_reg, lb_next;
    logic          dup_reg, dup_next;
    logic [31:0]   ns_reg, ns_next, nl_reg, nl_next;  // range to insert

    logic [31:0] ds, dl;
    logic        scan_done;
    logic [32:0] sum_a, sum_b, sum_c;
    logic        adj_prev, adj_next;
    logic [31:0] len1;

    assign ds = rd_data[63:32];
    assign dl = rd_data[31:0];
    assign scan_done = (cnt_reg == LAST_CNT) && !pend_reg;
    assign mem_raddr = cnt_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = (s_data.block_size == 32'd0) ? S_RESP : S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (scan_done) begin
                    state_next = (req_reg.command == CMD_ALLOC) ? S_ALLOC_WR : S_MERGE;
                end
            end
            S_ALLOC_WR: state_next = S_RESP;
            S_MERGE:    state_next = S_SCAN2;
            S_SCAN2: begin
                if (scan_done) begin
                    state_next = S_REL_WR;
                end
            end
            S_REL_WR: state_next = S_RESP;
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign sum_a = {1'b0, sa_reg} + {1'b0, la_reg};
    assign sum_b = {1'b0, req_reg.block_offset} + {1'b0, req_reg.block_size};
    assign adj_prev = fa_reg && (sum_a == {1'b0, req_reg.block_offset});
    assign adj_next = fb_reg && (sum_b == {1'b0, sb_reg});
    always_comb begin
        logic [32:0] s1;
        s1 = {1'b0, req_reg.block_size} + {1'b0, la_reg};
        len1 = adj_prev ? (s1[32] ? 32'hFFFF_FFFF : s1[31:0]) : req_reg.block_size;
    end
    assign sum_c = {1'b0, len1} + {1'b0, lb_reg};

    // datapath and outputs
    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        rsp_next   = rsp_reg;
        fa_next = fa_reg; ia_next = ia_reg; sa_next = sa_reg; la_next = la_reg;
        fb_next = fb_reg; ib_next = ib_reg; sb_next = sb_reg; lb_next = lb_reg;
        dup_next = dup_reg; ns_next = ns_reg; nl_next = nl_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        s_ready   = (state_reg == S_IDLE) && !init_reg;
        m_valid   = (state_reg == S_RESP);
        m_data    = rsp_reg;

        case (state_reg)
            S_IDLE: begin
                cnt_next = '0;
                fa_next  = 1'b0;
                fb_next  = 1'b0;
                dup_next = 1'b0;
                rsp_next = '{status: ST_DONE, granted_offset: 32'd0, granted_size: 32'd0};
                if (init_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = {32'd0, POOL_RESET};
                end
            end
            S_SCAN1: begin
                if (cnt_reg != LAST_CNT) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg && pval_reg) begin
                    if (req_reg.command == CMD_ALLOC) begin
                        if (dl >= req_reg.block_size &&
                            (!fa_reg || dl < la_reg || (dl == la_reg && ds < sa_reg))) begin
                            fa_next = 1'b1; ia_next = pidx_reg; sa_next = ds; la_next = dl;
                        end
                    end else if (ds < req_reg.block_offset) begin
                        if (!fa_reg || ds > sa_reg) begin
                            fa_next = 1'b1; ia_next = pidx_reg; sa_next = ds; la_next = dl;
                        end
                    end else if (!fb_reg || ds < sb_reg) begin
                        fb_next = 1'b1; ib_next = pidx_reg; sb_next = ds; lb_next = dl;
                    end
                end
            end
            S_ALLOC_WR: begin
                if (!fa_reg) begin
                    rsp_next.status = ST_NO_FIT;
                end else begin
                    rsp_next.granted_offset = sa_reg;
                    rsp_next.granted_size   = req_reg.block_size;
                    if (la_reg > req_reg.block_size) begin
                        mem_we    = 1'b1;
                        mem_waddr = ia_reg;
                        mem_wdata = {sa_reg + req_reg.block_size, la_reg - req_reg.block_size};
                    end else begin
                        valid_next[ia_reg] = 1'b0;
                    end
                end
            end
            S_MERGE: begin
                cnt_next = '0;
                ns_next  = adj_prev ? sa_reg : req_reg.block_offset;
                nl_next  = adj_next ? (sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0]) : len1;
                if (adj_prev) begin
                    valid_next[ia_reg] = 1'b0;
                end
                if (adj_next) begin
                    valid_next[ib_reg] = 1'b0;
                end
                fa_next = 1'b0;  // reused as free slot found
            end
            S_SCAN2: begin
                if (cnt_reg != LAST_CNT) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (pval_reg && ds == ns_reg) begin
                        dup_next = 1'b1;
                    end
                    if (!pval_reg && !fa_reg) begin
                        fa_next = 1'b1;
                        ia_next = pidx_reg;
                    end
                end
            end
            S_REL_WR: begin
                if (!dup_reg) begin
                    if (!fa_reg) begin
                        rsp_next.status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ia_reg;
                        mem_wdata = {ns_reg, nl_reg};
                        valid_next[ia_reg] = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        // pool reload, to be written only while idle; the block itself does not enforce this
        if (cfg_we) begin
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = {32'd0, cfg_wdata};
            valid_next = '0;
            valid_next[0] = (cfg_wdata != 32'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            init_reg  <= 1'b1;
            valid_reg <= MAX_FREE_RANGES'(1);
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we || state_reg == S_IDLE) begin
                init_reg <= 1'b0;
            end
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= ((state_reg == S_SCAN1) || (state_reg == S_SCAN2)) &&
                         (cnt_reg != LAST_CNT);
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg <= cnt_reg[IW-1:0];
        pval_reg <= valid_reg[cnt_reg[IW-1:0]];
        rsp_reg  <= rsp_next;
        fa_reg <= fa_next; ia_reg <= ia_next; sa_reg <= sa_next; la_reg <= la_next;
        fb_reg <= fb_next; ib_reg <= ib_next; sb_reg <= sb_next; lb_reg <= lb_next;
        dup_reg <= dup_next; ns_reg <= ns_next; nl_reg <= nl_next;
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

endmodule

### hdl/bfra_checker.sv
// Port-level checks for the best-fit range allocator, bound to the top level.
module bfra_checker import bfra_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != ST_UNUSED)
        else $error("undefined status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_DONE |->
            m_data.granted_offset == 32'd0 && m_data.granted_size == 32'd0)
        else $error("grant on failed transaction");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    a_busy_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

endmodule

bind best_fit_range_allocator bfra_checker u_bfra_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/best_fit_range_allocator_tb.sv
// Testbench for the best-fit range allocator: random driver, predicting scoreboard.
module best_fit_range_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfra_pkg::*;

    localparam int NRANGES = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    best_fit_range_allocator #(.MAX_FREE_RANGES(NRANGES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state: free table mirror
    logic [31:0] pool_bytes;
    logic [31:0] tbl_start [NRANGES];
    logic [31:0] tbl_len [NRANGES];
    logic        tbl_used [NRANGES];

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   quiet_tail = 0;
    bit   hold_recv = 0;
    int   send_gap = 0;
    int   recv_gap = 0;

    task automatic load_pool(input logic [31:0] sz);
        pool_bytes = sz;
        for (int i = 0; i < NRANGES; i++) begin
            tbl_start[i] = '0;
            tbl_len[i] = '0;
            tbl_used[i] = 1'b0;
        end
        if (sz != 0) begin
            tbl_len[0] = sz;
            tbl_used[0] = 1'b1;
        end
    endtask

    task automatic add_req(input req_t q);
        pending_reqs = {pending_reqs, q};
    endtask

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic rsp_t predict_grant(input req_t rq);
        rsp_t r;
        int best, prv, nxt, slot;
        logic [31:0] st, ln;
        r = '0;
        r.status = ST_DONE;
        if (rq.block_size == 0) return r;
        if (rq.command == CMD_ALLOC) begin
            best = -1;
            for (int i = 0; i < NRANGES; i++) begin
                if (!tbl_used[i] || tbl_len[i] < rq.block_size) continue;
                if (best < 0 || tbl_len[i] < tbl_len[best] ||
                    (tbl_len[i] == tbl_len[best] && tbl_start[i] < tbl_start[best]))
                    best = i;
            end
            if (best < 0) begin
                r.status = ST_NO_FIT;
                return r;
            end
            r.granted_offset = tbl_start[best];
            r.granted_size = rq.block_size;
            if (tbl_len[best] > rq.block_size) begin
                tbl_start[best] = tbl_start[best] + rq.block_size;
                tbl_len[best] = tbl_len[best] - rq.block_size;
            end else begin
                tbl_used[best] = 1'b0;
                tbl_start[best] = '0;
                tbl_len[best] = '0;
            end
            return r;
        end
        prv = -1;
        nxt = -1;
        slot = -1;
        st = rq.block_offset;
        ln = rq.block_size;
        for (int i = 0; i < NRANGES; i++) begin
            if (!tbl_used[i]) continue;
            if (tbl_start[i] < rq.block_offset) begin
                if (prv < 0 || tbl_start[i] > tbl_start[prv]) prv = i;
            end else if (nxt < 0 || tbl_start[i] < tbl_start[nxt]) begin
                nxt = i;
            end
        end
        if (prv >= 0 && ({1'b0, tbl_start[prv]} + {1'b0, tbl_len[prv]}) ==
                        {1'b0, rq.block_offset}) begin
            st = tbl_start[prv];
            ln = sat_sum(ln, tbl_len[prv]);
            tbl_used[prv] = 1'b0;
            tbl_start[prv] = '0;
            tbl_len[prv] = '0;
        end
        if (nxt >= 0 && ({1'b0, rq.block_offset} + {1'b0, rq.block_size}) ==
                        {1'b0, tbl_start[nxt]}) begin
            ln = sat_sum(ln, tbl_len[nxt]);
            tbl_used[nxt] = 1'b0;
            tbl_start[nxt] = '0;
            tbl_len[nxt] = '0;
        end
        for (int i = 0; i < NRANGES; i++) begin
            if (tbl_used[i] && tbl_start[i] == st) return r;
            if (!tbl_used[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        tbl_used[slot] = 1'b1;
        tbl_start[slot] = st;
        tbl_len[slot] = ln;
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_rsps = {expected_rsps, predict_grant(s_data)};
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver idling
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", m_data);
                end else if (m_data !== expected_rsps[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp st=%0d off=%h sz=%h got st=%0d off=%h sz=%h",
                                 expected_rsps[0].status, expected_rsps[0].granted_offset,
                                 expected_rsps[0].granted_size, m_data.status,
                                 m_data.granted_offset, m_data.granted_size);
                    void'(expected_rsps.pop_front());
                end else begin
                    void'(expected_rsps.pop_front());
                end
            end
            if (hold_recv) begin
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 15);
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic req_t make_req(input logic cmd, input logic [31:0] off,
                                      input logic [31:0] sz);
        req_t q;
        q.command = cmd;
        q.block_offset = off;
        q.block_size = sz;
        return q;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_pool(input logic [31:0] sz);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= sz;
        @(posedge aclk);
        cfg_we <= 1'b0;
        load_pool(sz);
    endtask

    // mostly well-formed alloc/release traffic with random content, plus fully random requests
    task automatic random_phase(input int n, input logic [31:0] span);
        logic [31:0] held_off [$];
        logic [31:0] held_sz [$];
        logic [31:0] sz, off;
        int k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    sz = $urandom_range(1, span);
                    add_req(make_req(CMD_ALLOC, $urandom, sz));
                end
                4, 5, 6: begin
                    // release a range held back by an earlier isolated release, else a random slice of pool
                    if (held_off.size() > 0) begin
                        k = $urandom_range(0, held_off.size() - 1);
                        off = held_off[k];
                        sz = held_sz[k];
                        held_off.delete(k);
                        held_sz.delete(k);
                    end else begin
                        off = $urandom_range(0, span * 8);
                        sz = $urandom_range(1, span);
                    end
                    add_req(make_req(CMD_RELEASE, off, sz));
                end
                7: begin
                    off = $urandom_range(0, span * 16) * 4;
                    sz = $urandom_range(1, 3);
                    add_req(make_req(CMD_RELEASE, off, sz));
                    held_off = {held_off, off + sz + 1};
                    held_sz = {held_sz, 32'd1};
                end
                8: add_req(make_req(1'($urandom_range(0, 1)), $urandom,
                                    $urandom_range(0, 1) ? 32'd0 : $urandom));
                default: add_req(make_req(1'($urandom_range(0, 1)), $urandom, $urandom));
            endcase
        end
    endtask

    initial begin
        load_pool(POOL_RESET);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero sizes, extremes, exact fit, merges, overflow, no fit
        add_req(make_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0));
        add_req(make_req(CMD_RELEASE, 32'h1234, 32'd0));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'd100));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'd50));
        add_req(make_req(CMD_RELEASE, 32'd0, 32'd100));
        add_req(make_req(CMD_RELEASE, 32'd100, 32'd50));
        add_req(make_req(CMD_RELEASE, 32'd0, 32'd10));
        add_req(make_req(CMD_RELEASE, 32'hFFFF_FFF0, 32'h20));
        add_req(make_req(CMD_RELEASE, 32'hF000_0000, 32'hFFFF_FFFF));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'h4000_0000));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'h4000_0001));
        drain();
        write_pool(32'd0);
        add_req(make_req(CMD_ALLOC, 32'd0, 32'd1));
        add_req(make_req(CMD_RELEASE, 32'd10, 32'd5));
        add_req(make_req(CMD_RELEASE, 32'd15, 32'd5));
        add_req(make_req(CMD_RELEASE, 32'd5, 32'd5));
        add_req(make_req(CMD_ALLOC, 32'd0, 32'd15));
        drain();
        write_pool(32'hFFFF_FFFF);
        add_req(make_req(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF));
        add_req(make_req(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        add_req(make_req(CMD_RELEASE, 32'd0, 32'hFFFF_FFFF));
        drain();
        // fill the table: isolated releases until it reports full
        write_pool(32'd0);
        for (int i = 0; i < NRANGES + 3; i++)
            add_req(make_req(CMD_RELEASE, i * 16, 32'd4));
        add_req(make_req(CMD_RELEASE, 32'd4, 32'd4));
        drain();

        // long receiver stall while sender keeps offering
        write_pool(32'd4096);
        random_phase(150, 64);
        hold_recv = 1;
        repeat (3000) @(posedge aclk);
        hold_recv = 0;
        drain();

        write_pool(32'd100000);
        random_phase(250, 500);
        drain();
        write_pool($urandom);
        random_phase(250, 32'h0100_0000);
        drain();
        quiet_tail = 1;
        write_pool(32'd1 << $urandom_range(4, 20));
        random_phase(200, 200);
        drain();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### files.f
hdl/bfra_pkg.sv
hdl/best_fit_range_allocator.sv
hdl/bfra_checker.sv
tb/best_fit_range_allocator_tb.sv
